// ===== rtl/sacl_pkg.sv =====
// Shared types and constants for the set-associative LRU cache tag store.
// Holds transfer structs, command and outcome codes, register indexes and defaults.
// No dependencies.
`timescale 1ns / 1ps

package sacl_pkg;

  // Default sizing handed to the top level
  localparam int MAX_SET_BITS_DEF = 6;
  localparam int MAX_WAYS_DEF     = 8;
  localparam int ADDR_WIDTH_DEF   = 64;
  localparam int COUNT_WIDTH_DEF  = 32;

  // Fixed field widths of the transfer ports
  localparam int CMD_W      = 2;
  localparam int ADDR_W     = 64;
  localparam int OUTCOME_W  = 2;
  localparam int WAY_OUT_W  = 3;
  localparam int TOTAL_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SET_BITS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BITS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_WAYS = 2'd2;

  // Register widths and reset values
  localparam int SET_BITS_W    = 3;
  localparam int BLOCK_BITS_W  = 5;
  localparam int ACTIVE_WAYS_W = 4;
  localparam logic [SET_BITS_W-1:0]    SET_BITS_RST    = 3'd4;
  localparam logic [BLOCK_BITS_W-1:0]  BLOCK_BITS_RST  = 5'd4;
  localparam logic [ACTIVE_WAYS_W-1:0] ACTIVE_WAYS_RST = 4'd1;

  // Access kinds
  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_STORE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MODIFY = 2'd2;
  localparam logic [CMD_W-1:0] CMD_FETCH  = 2'd3;

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_IGNORE = 2'd0,
    OUT_HIT    = 2'd1,
    OUT_FILL   = 2'd2,
    OUT_EVICT  = 2'd3
  } outcome_e;

  // Controller states, one-hot
  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_LOOK  = 3'b100
  } state_e;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] address;
  } req_t;

  typedef struct packed {
    outcome_e               outcome;
    logic [WAY_OUT_W-1:0]   way_used;
    logic [TOTAL_W-1:0]     hit_total;
    logic [TOTAL_W-1:0]     miss_total;
    logic [TOTAL_W-1:0]     evict_total;
  } rsp_t;

endpackage

// ===== rtl/sacl_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the per-set row store. No dependencies.
`timescale 1ns / 1ps

module sacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one entry, read one entry per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/set_assoc_cache_lru_sim.sv =====
// Top level of the set-associative LRU cache tag store.
// Depends on sacl_pkg for types and codes and on sacl_ram for the row store.
`timescale 1ns / 1ps

// Usage
//   Command channel: drive req_i and raise start; the access is taken at the
//   rising edge where start is high and busy is low. busy stays high while an
//   access is in flight and during the clearing pass after reset.
//   Result channel: done_o is high for exactly one cycle with rsp_o holding the
//   outcome, the way used and the running hit, miss and evict totals. The
//   receiver cannot stall; a result must be taken in its one cycle.
//   Configuration: cfg_we_i with cfg_idx_i and cfg_data_i writes set_bits (0),
//   block_bits (1) or active_ways (2) at the clock edge; write only while idle.
// Timing
//   The set row is read from the RAM in the accept cycle, then compared,
//   updated and written back (not for a fetch) in the next. done_o rises
//   the cycle after that; a new access may be accepted in that same cycle,
//   and none is taken while a lookup is in flight. The single row RAM
//   read-modify-write is why accesses cannot overlap.
// Reset
//   After rst_ni is released the row RAM is cleared, one set per cycle, through
//   all 2**MAX_SET_BITS sets with busy high. Totals reset to zero.
module set_assoc_cache_lru_sim #(
  parameter int MAX_SET_BITS = sacl_pkg::MAX_SET_BITS_DEF,
  parameter int MAX_WAYS     = sacl_pkg::MAX_WAYS_DEF,
  parameter int ADDR_WIDTH   = sacl_pkg::ADDR_WIDTH_DEF,
  parameter int COUNT_WIDTH  = sacl_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  sacl_pkg::req_t                      req_i,
  output logic                                done_o,
  output sacl_pkg::rsp_t                      rsp_o,
  input  logic                                cfg_we_i,
  input  logic [sacl_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [sacl_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int ROW_DEPTH = 1 << MAX_SET_BITS;
  localparam int SET_W    = MAX_SET_BITS;
  localparam int REC_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WAY_W    = REC_W;
  localparam int TAG_W    = ADDR_WIDTH;
  localparam int REC_OFS  = MAX_WAYS;
  localparam int TAG_OFS  = MAX_WAYS * (1 + REC_W);
  localparam int ROW_W    = MAX_WAYS * (1 + REC_W + TAG_W);
  localparam int SETB_W   = 4;
  localparam int SH_W     = 6;
  localparam int WCNT_W   = sacl_pkg::ACTIVE_WAYS_W + 1;
  localparam logic [REC_W-1:0]       REC_MAX = REC_W'(MAX_WAYS - 1);
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  // Configuration registers
  logic [sacl_pkg::SET_BITS_W-1:0]    set_bits_q;
  logic [sacl_pkg::BLOCK_BITS_W-1:0]  block_bits_q;
  logic [sacl_pkg::ACTIVE_WAYS_W-1:0] active_ways_q;

  // Control and access context
  sacl_pkg::state_e  state_q, state_d;
  logic [SET_W-1:0]  clr_q;
  logic [SET_W-1:0]  set_q;
  logic [TAG_W-1:0]  tag_q;
  logic [sacl_pkg::CMD_W-1:0] cmd_q;
  logic [MAX_WAYS-1:0] act_q;

  // Totals and result
  logic [COUNT_WIDTH-1:0] hit_cnt_q, miss_cnt_q, evict_cnt_q;
  logic [COUNT_WIDTH-1:0] hit_cnt_d, miss_cnt_d, evict_cnt_d;
  sacl_pkg::rsp_t rsp_q, rsp_d;
  logic           done_q;

  // Address split and way mask for the access being taken
  logic [ADDR_WIDTH-1:0] addr_w;
  logic [ADDR_WIDTH-1:0] addr_sh;
  logic [SETB_W-1:0]     s_eff;
  logic [SET_W-1:0]      set_idx;
  logic [TAG_W-1:0]      tag_in;
  logic [WCNT_W-1:0]     ways_eff;
  logic [MAX_WAYS-1:0]   act_d;
  logic                  accept;

  // RAM ports
  logic              mem_we;
  logic [SET_W-1:0]  mem_waddr;
  logic [ROW_W-1:0]  mem_wdata;
  logic [ROW_W-1:0]  mem_rdata;
  logic [ROW_W-1:0]  row_new;

  // Unpacked row view
  logic [MAX_WAYS-1:0] vld;
  logic [REC_W-1:0]    rec [MAX_WAYS];
  logic [TAG_W-1:0]    tag [MAX_WAYS];

  // Lookup results
  logic             hit, found;
  logic [WAY_W-1:0] hit_way, fill_way, victim, way_sel;
  logic [REC_W-1:0] best_rec, old_rec;
  logic             is_fetch, is_modify;
  logic [1:0]       hit_inc;

  function automatic logic [COUNT_WIDTH-1:0] sat_add(logic [COUNT_WIDTH-1:0] c,
                                                      logic [1:0] inc);
    logic [COUNT_WIDTH-1:0] inc_w;
    inc_w = COUNT_WIDTH'(inc);
    if (c > CNT_MAX - inc_w) begin
      return CNT_MAX;
    end
    return c + inc_w;
  endfunction

  assign accept = start && (state_q == sacl_pkg::S_IDLE);
  assign busy   = (state_q != sacl_pkg::S_IDLE);

  // Split the incoming address by the configured field sizes
  always_comb begin
    addr_w  = req_i.address[ADDR_WIDTH-1:0];
    s_eff   = (SETB_W'(set_bits_q) > SETB_W'(MAX_SET_BITS)) ? SETB_W'(MAX_SET_BITS)
                                                            : SETB_W'(set_bits_q);
    addr_sh = addr_w >> block_bits_q;
    set_idx = addr_sh[SET_W-1:0] & ~({SET_W{1'b1}} << s_eff);
    tag_in  = TAG_W'(addr_w >> (SH_W'(s_eff) + SH_W'(block_bits_q)));
    if (active_ways_q == '0) begin
      ways_eff = WCNT_W'(1);
    end else if (WCNT_W'(active_ways_q) > WCNT_W'(MAX_WAYS)) begin
      ways_eff = WCNT_W'(MAX_WAYS);
    end else begin
      ways_eff = WCNT_W'(active_ways_q);
    end
    for (int v = 0; v < MAX_WAYS; v++) begin
      act_d[v] = (WCNT_W'(v) < ways_eff);
    end
  end

  // Unpack the row read for the access in flight
  always_comb begin
    for (int v = 0; v < MAX_WAYS; v++) begin
      vld[v] = mem_rdata[v];
      rec[v] = mem_rdata[REC_OFS + v*REC_W +: REC_W];
      tag[v] = mem_rdata[TAG_OFS + v*TAG_W +: TAG_W];
    end
  end

  // Look up the tag, pick the fill way or the LRU victim
  always_comb begin
    hit      = 1'b0;
    hit_way  = '0;
    found    = 1'b0;
    fill_way = '0;
    victim   = '0;
    best_rec = rec[0];
    for (int v = 0; v < MAX_WAYS; v++) begin
      if (!hit && act_q[v] && vld[v] && (tag[v] == tag_q)) begin
        hit     = 1'b1;
        hit_way = WAY_W'(v);
      end
      if (!found && act_q[v] && !vld[v]) begin
        found    = 1'b1;
        fill_way = WAY_W'(v);
      end
    end
    for (int v = 1; v < MAX_WAYS; v++) begin
      if (act_q[v] && (rec[v] > best_rec)) begin
        best_rec = rec[v];
        victim   = WAY_W'(v);
      end
    end
    way_sel = hit ? hit_way : (found ? fill_way : victim);
    old_rec = rec[way_sel];
  end

  // Build the updated row: selected way becomes most recent, younger lines age (every other line on a miss)
  always_comb begin
    row_new = mem_rdata;
    for (int v = 0; v < MAX_WAYS; v++) begin
      if (WAY_W'(v) == way_sel) begin
        row_new[v] = 1'b1;
        row_new[REC_OFS + v*REC_W +: REC_W] = '0;
        if (!hit) begin
          row_new[TAG_OFS + v*TAG_W +: TAG_W] = tag_q;
        end
      end else if (act_q[v] && vld[v] && (!hit || (rec[v] < old_rec))
                   && (rec[v] != REC_MAX)) begin
        row_new[REC_OFS + v*REC_W +: REC_W] = rec[v] + REC_W'(1);
      end
    end
  end

  // Form the result and the next totals
  always_comb begin
    is_fetch    = (cmd_q == sacl_pkg::CMD_FETCH);
    is_modify   = (cmd_q == sacl_pkg::CMD_MODIFY);
    hit_inc     = {1'b0, hit} + {1'b0, is_modify};
    hit_cnt_d   = hit_cnt_q;
    miss_cnt_d  = miss_cnt_q;
    evict_cnt_d = evict_cnt_q;
    rsp_d.outcome  = sacl_pkg::OUT_IGNORE;
    rsp_d.way_used = '0;
    if (!is_fetch) begin
      hit_cnt_d = sat_add(hit_cnt_q, hit_inc);
      if (!hit) begin
        miss_cnt_d = sat_add(miss_cnt_q, 2'd1);
      end
      if (!hit && !found) begin
        evict_cnt_d = sat_add(evict_cnt_q, 2'd1);
      end
      rsp_d.way_used = sacl_pkg::WAY_OUT_W'(way_sel);
      if (hit) begin
        rsp_d.outcome = sacl_pkg::OUT_HIT;
      end else if (found) begin
        rsp_d.outcome = sacl_pkg::OUT_FILL;
      end else begin
        rsp_d.outcome = sacl_pkg::OUT_EVICT;
      end
    end
    rsp_d.hit_total   = sacl_pkg::TOTAL_W'(hit_cnt_d);
    rsp_d.miss_total  = sacl_pkg::TOTAL_W'(miss_cnt_d);
    rsp_d.evict_total = sacl_pkg::TOTAL_W'(evict_cnt_d);
  end

  // Sequence clear, idle and lookup
  always_comb begin
    state_d = state_q;
    case (state_q)
      sacl_pkg::S_CLEAR: begin
        if (clr_q == {SET_W{1'b1}}) begin
          state_d = sacl_pkg::S_IDLE;
        end
      end
      sacl_pkg::S_IDLE: begin
        if (start) begin
          state_d = sacl_pkg::S_LOOK;
        end
      end
      sacl_pkg::S_LOOK: begin
        state_d = sacl_pkg::S_IDLE;
      end
      default: begin
        state_d = sacl_pkg::S_CLEAR;
      end
    endcase
  end

  // Drive the row store write port: zero rows while clearing, updates on non-fetch lookups
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = set_q;
    mem_wdata = row_new;
    if (state_q == sacl_pkg::S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = '0;
    end else if ((state_q == sacl_pkg::S_LOOK) && !is_fetch) begin
      mem_we = 1'b1;
    end
  end

  sacl_ram #(
    .WIDTH (ROW_W),
    .DEPTH (ROW_DEPTH)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (set_idx),
    .rdata_o (mem_rdata)
  );

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sacl_pkg::S_CLEAR;
      clr_q       <= '0;
      done_q      <= 1'b0;
      hit_cnt_q   <= '0;
      miss_cnt_q  <= '0;
      evict_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == sacl_pkg::S_LOOK);
      if (state_q == sacl_pkg::S_CLEAR) begin
        clr_q <= clr_q + SET_W'(1);
      end
      if (state_q == sacl_pkg::S_LOOK) begin
        hit_cnt_q   <= hit_cnt_d;
        miss_cnt_q  <= miss_cnt_d;
        evict_cnt_q <= evict_cnt_d;
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q    <= sacl_pkg::SET_BITS_RST;
      block_bits_q  <= sacl_pkg::BLOCK_BITS_RST;
      active_ways_q <= sacl_pkg::ACTIVE_WAYS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sacl_pkg::REG_SET_BITS: begin
          set_bits_q <= cfg_data_i[sacl_pkg::SET_BITS_W-1:0];
        end
        sacl_pkg::REG_BLOCK_BITS: begin
          block_bits_q <= cfg_data_i[sacl_pkg::BLOCK_BITS_W-1:0];
        end
        sacl_pkg::REG_ACTIVE_WAYS: begin
          active_ways_q <= cfg_data_i[sacl_pkg::ACTIVE_WAYS_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Hold the access context and the result
  always_ff @(posedge clk_i) begin
    if (accept) begin
      set_q <= set_idx;
      tag_q <= tag_in;
      cmd_q <= req_i.cmd;
      act_q <= act_d;
    end
    if (state_q == sacl_pkg::S_LOOK) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // A result strobe is raised only after a lookup
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == sacl_pkg::S_LOOK))
    else $error("result strobe without a lookup");

  // A lookup always returns to idle in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sacl_pkg::S_LOOK) |=> (state_q == sacl_pkg::S_IDLE))
    else $error("lookup did not return to idle");

  // The row store is never written while idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q != sacl_pkg::S_IDLE))
    else $error("row store written while idle");

  // Totals never decrease
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sacl_pkg::S_LOOK) |=> ((hit_cnt_q >= $past(hit_cnt_q))
      && (miss_cnt_q >= $past(miss_cnt_q)) && (evict_cnt_q >= $past(evict_cnt_q))))
    else $error("total decreased");

  // An eviction is reported only with nonzero miss and evict totals
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (rsp_o.outcome == sacl_pkg::OUT_EVICT)) |->
      ((miss_cnt_q != '0) && (evict_cnt_q != '0)))
    else $error("eviction reported with empty totals");

endmodule
